@@ hdl/m3au_pkg.sv @@
// Shared types, constants and the address helper for the 3x3 matrix arithmetic unit.
package m3au_pkg;

  localparam int DIM         = 3;
  localparam int NELEM       = DIM * DIM;
  localparam int IDX_W       = $clog2(DIM);
  localparam int ADDR_W      = $clog2(NELEM);
  localparam int DATA_W      = 32;
  localparam int FLD_IDX_W   = 2;
  localparam int OPC_W       = 3;
  localparam int IN_FIELDS_W = 2 * FLD_IDX_W + 2 * DATA_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * FLD_IDX_W + DATA_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD = 3'd0,
    OP_MUL  = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_TRN  = 3'd4
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_ISSUE
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
  } mem_rd_t;

  // Row-major address of element (row, col).
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    logic [ADDR_W+IDX_W-1:0] sum;
    begin
      sum = (ADDR_W+IDX_W)'(row) * (ADDR_W+IDX_W)'(DIM) + (ADDR_W+IDX_W)'(col);
      elem_addr = sum[ADDR_W-1:0];
    end
  endfunction

endpackage

@@ hdl/m3au_store.sv @@
// Storage for matrices A and B: one write port, one registered read port each.
module m3au_store
  import m3au_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mem_wr_t           wr,
  input  mem_rd_t           rd,
  output logic [DATA_W-1:0] rd_a,
  output logic [DATA_W-1:0] rd_b
);

  logic [DATA_W-1:0] mem_a [NELEM];
  logic [DATA_W-1:0] mem_b [NELEM];
  logic [NELEM-1:0]  vld_r;
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;

  // An entry never loaded since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_a[wr.addr] <= wr.a;
      mem_b[wr.addr] <= wr.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_a_r <= vld_r[rd.a_addr] ? mem_a[rd.a_addr] : '0;
      rd_b_r <= vld_r[rd.b_addr] ? mem_b[rd.b_addr] : '0;
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

@@ hdl/matrix3x3_arithmetic_unit.sv @@
// Flow: a load word gives no result and leaves the input ready. Add, subtract and transpose
// issue their elements after acceptance and multiply issues each term; every read passes the
// read register, stage 2 and the output register. The input stays closed while they issue;
// each memory has one read port, so a product element needs three reads.
// Result words leave one per cycle while out_tready is high, or one per three reads for multiply.
// A stall freezes the pipe. Reset (rst_n low) clears both matrices and empties the pipe.
module matrix3x3_arithmetic_unit
  import m3au_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // row_index[1:0], col_index[3:2],
                                             // a_value[35:4], b_value[67:36]
  input  logic [OPC_W-1:0]       in_tuser,   // opcode[2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_row[1:0], out_col[3:2], value[35:4]
  output logic                   out_tlast   // last
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic [IDX_W-1:0] row_r, row_nxt, col_r, col_nxt, k_r, k_nxt;

  logic in_acc, is_calc, adv, issuing, iss_kfirst, iss_klast;
  logic [FLD_IDX_W-1:0] ld_row, ld_col;
  logic ld_in_range;

  mem_wr_t wr;
  mem_rd_t rd;
  logic [DATA_W-1:0] rd_a, rd_b;

  logic             s1_valid_r, s1_kfirst_r, s1_klast_r;
  op_t              s1_op_r;
  logic [IDX_W-1:0] s1_row_r, s1_col_r;

  logic              s2_valid_r, s2_kfirst_r, s2_klast_r;
  logic [IDX_W-1:0]  s2_row_r, s2_col_r;
  logic [DATA_W-1:0] s2_val_r, s2_val_nxt;

  logic [DATA_W-1:0] acc_r, acc_sum;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_row_r, out_col_r;
  logic [DATA_W-1:0] out_val_r;
  logic              out_last_r;

  assign in_acc  = in_tvalid && in_tready;
  assign is_calc = (in_tuser == OP_MUL) || (in_tuser == OP_ADD) ||
                   (in_tuser == OP_SUB) || (in_tuser == OP_TRN);
  // The whole pipe advances unless a result word is waiting on a stalled sink.
  assign adv     = !out_valid_r || out_tready;

  assign iss_kfirst = (op_r != OP_MUL) || (k_r == '0);
  assign iss_klast  = (op_r != OP_MUL) || (k_r == IDX_LAST);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && is_calc) state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (adv && iss_klast && row_r == IDX_LAST && col_r == IDX_LAST) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_tready = 1'b0;
    issuing   = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_ISSUE: issuing   = 1'b1;
      default: begin
        in_tready = 1'b0;
        issuing   = 1'b0;
      end
    endcase
  end

  // Element and inner-product counters.
  always_comb begin
    op_nxt  = op_r;
    row_nxt = row_r;
    col_nxt = col_r;
    k_nxt   = k_r;
    if (in_acc && is_calc) begin
      op_nxt  = op_t'(in_tuser);
      row_nxt = '0;
      col_nxt = '0;
      k_nxt   = '0;
    end else if (issuing && adv) begin
      if (!iss_klast) begin
        k_nxt = k_r + IDX_W'(1);
      end else begin
        k_nxt = '0;
        if (col_r == IDX_LAST) begin
          col_nxt = '0;
          row_nxt = (row_r == IDX_LAST) ? '0 : row_r + IDX_W'(1);
        end else begin
          col_nxt = col_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_LOAD;
      row_r   <= '0;
      col_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      k_r     <= k_nxt;
    end
  end

  // Load path.
  assign ld_row      = in_tdata[FLD_IDX_W-1:0];
  assign ld_col      = in_tdata[2*FLD_IDX_W-1:FLD_IDX_W];
  assign ld_in_range = ({30'd0, ld_row} < 32'(DIM)) && ({30'd0, ld_col} < 32'(DIM));

  always_comb begin
    wr.en   = in_acc && (in_tuser == OP_LOAD) && ld_in_range;
    wr.addr = elem_addr(IDX_W'(ld_row), IDX_W'(ld_col));
    wr.a    = in_tdata[2*FLD_IDX_W+DATA_W-1:2*FLD_IDX_W];
    wr.b    = in_tdata[2*FLD_IDX_W+2*DATA_W-1:2*FLD_IDX_W+DATA_W];
  end

  // Read addresses: A[r][k] and B[k][c] for a product, A[c][r] for transpose.
  always_comb begin
    rd.en = issuing && adv;
    case (op_r)
      OP_MUL: begin
        rd.a_addr = elem_addr(row_r, k_r);
        rd.b_addr = elem_addr(k_r, col_r);
      end
      OP_TRN: begin
        rd.a_addr = elem_addr(col_r, row_r);
        rd.b_addr = elem_addr(col_r, row_r);
      end
      default: begin
        rd.a_addr = elem_addr(row_r, col_r);
        rd.b_addr = elem_addr(row_r, col_r);
      end
    endcase
  end

  m3au_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .rd    (rd),
    .rd_a  (rd_a),
    .rd_b  (rd_b)
  );

  // Stage 1 travels with the registered read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= issuing;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r     <= op_r;
      s1_row_r    <= row_r;
      s1_col_r    <= col_r;
      s1_kfirst_r <= iss_kfirst;
      s1_klast_r  <= iss_klast;
    end
  end

  // Stage 2: one product, sum, difference or pass-through.
  always_comb begin
    case (s1_op_r)
      OP_MUL:  s2_val_nxt = rd_a * rd_b;
      OP_ADD:  s2_val_nxt = rd_a + rd_b;
      OP_SUB:  s2_val_nxt = rd_a - rd_b;
      default: s2_val_nxt = rd_a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_val_r    <= s2_val_nxt;
      s2_row_r    <= s1_row_r;
      s2_col_r    <= s1_col_r;
      s2_kfirst_r <= s1_kfirst_r;
      s2_klast_r  <= s1_klast_r;
    end
  end

  // Stage 3: accumulate; for non-product operations each term is both first and last.
  assign acc_sum = (s2_kfirst_r ? '0 : acc_r) + s2_val_r;

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      acc_r <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r && s2_klast_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r && s2_klast_r) begin
      out_val_r  <= acc_sum;
      out_row_r  <= s2_row_r;
      out_col_r  <= s2_col_r;
      out_last_r <= (s2_row_r == IDX_LAST) && (s2_col_r == IDX_LAST);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_val_r,
                       FLD_IDX_W'(out_col_r), FLD_IDX_W'(out_row_r)};

endmodule

@@ hdl/m3au_checker.sv @@
// Port-level checks for the matrix arithmetic unit, bound to the top level.
module m3au_checker
  import m3au_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [OPC_W-1:0]       in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  localparam logic [FLD_IDX_W-1:0] FLD_LAST = FLD_IDX_W'(DIM - 1);

  // A word held against a stalled sink must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // After a load the input is ready again in the next cycle.
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_LOAD |=> in_tready)
    else $error("input not ready after a load");

  // An operation keeps the input closed while its elements are issued.
  a_op_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    (in_tuser == OP_MUL || in_tuser == OP_ADD || in_tuser == OP_SUB || in_tuser == OP_TRN)
    |=> !in_tready)
    else $error("input ready while an operation is running");

  // The final word of a result is always the bottom-right element.
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
    out_tdata[FLD_IDX_W-1:0] == FLD_LAST && out_tdata[2*FLD_IDX_W-1:FLD_IDX_W] == FLD_LAST)
    else $error("last flag on a word other than the final element");

endmodule

bind matrix3x3_arithmetic_unit m3au_checker u_m3au_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ bench/matrix_checker.sv @@
// Checker for the 3x3 matrix unit: tracks both matrices and compares every result word.
`timescale 1ns / 100ps

module matrix_checker
  import m3au_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [OPC_W-1:0]       in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  output int                     mismatch_count,
  output int                     elems_outstanding
);

  typedef struct packed {
    logic [FLD_IDX_W-1:0] row;
    logic [FLD_IDX_W-1:0] col;
    logic [DATA_W-1:0]    value;
    logic                 last;
  } elem_t;

  logic [DATA_W-1:0] mat_a [NELEM];
  logic [DATA_W-1:0] mat_b [NELEM];
  elem_t             expected_elems [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [DATA_W-1:0] matrix_elem(input op_t opc, input int r, input int c);
    logic [DATA_W-1:0] acc;
    acc = '0;
    case (opc)
      OP_MUL: begin
        for (int k = 0; k < DIM; k++) begin
          acc = acc + mat_a[r*DIM + k] * mat_b[k*DIM + c];
        end
      end
      OP_ADD:  acc = mat_a[r*DIM + c] + mat_b[r*DIM + c];
      OP_SUB:  acc = mat_a[r*DIM + c] - mat_b[r*DIM + c];
      default: acc = mat_a[c*DIM + r];
    endcase
    return acc;
  endfunction

  // Apply one accepted word: update both matrices, queue nine elements, or do nothing.
  task automatic apply_command();
    logic [FLD_IDX_W-1:0] row;
    logic [FLD_IDX_W-1:0] col;
    logic [DATA_W-1:0]    a_val;
    logic [DATA_W-1:0]    b_val;
    elem_t                e;
    row   = in_tdata[1:0];
    col   = in_tdata[3:2];
    a_val = in_tdata[35:4];
    b_val = in_tdata[67:36];
    case (in_tuser)
      OP_LOAD: begin
        // An index of three points outside the matrix; such a load is dropped.
        if (row < DIM && col < DIM) begin
          mat_a[row*DIM + col] = a_val;
          mat_b[row*DIM + col] = b_val;
        end
      end
      OP_MUL, OP_ADD, OP_SUB, OP_TRN: begin
        for (int r = 0; r < DIM; r++) begin
          for (int c = 0; c < DIM; c++) begin
            e.row   = FLD_IDX_W'(r);
            e.col   = FLD_IDX_W'(c);
            e.value = matrix_elem(op_t'(in_tuser), r, c);
            e.last  = (r == DIM-1) && (c == DIM-1);
            expected_elems.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result_word();
    elem_t got;
    elem_t want;
    got.row   = out_tdata[1:0];
    got.col   = out_tdata[3:2];
    got.value = out_tdata[35:4];
    got.last  = out_tlast;
    if (expected_elems.size() == 0) begin
      report_mismatch($sformatf("unexpected word row=%0d col=%0d value=%h last=%b",
                                got.row, got.col, got.value, got.last));
    end else begin
      want = expected_elems.pop_front();
      if (got.row !== want.row || got.col !== want.col ||
          got.value !== want.value || got.last !== want.last) begin
        report_mismatch($sformatf("got row=%0d col=%0d value=%h last=%b, want %0d %0d %h %b",
                                  got.row, got.col, got.value, got.last,
                                  want.row, want.col, want.value, want.last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NELEM; i++) begin
        mat_a[i] = '0;
        mat_b[i] = '0;
      end
      expected_elems.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        check_result_word();
      end
      if (in_tvalid && in_tready) begin
        apply_command();
      end
    end
    elems_outstanding <= expected_elems.size();
  end

endmodule

@@ bench/testbench.sv @@
// Top of the matrix unit bench: clock, reset, command stimulus with idling phases, verdict.
`timescale 1ns / 100ps

module testbench;
  import m3au_pkg::*;

  // Opcodes the block does not define; they must be ignored.
  localparam logic [OPC_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OPC_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OPC_W-1:0] OP_RSVD7 = 3'd7;
  localparam int RANDOM_WORDS = 370;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [OPC_W-1:0]       in_tuser   = OP_LOAD;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  int                     mismatch_count;
  int                     elems_outstanding;
  int                     send_idle_pct  = 0;
  int                     recv_stall_pct = 0;

  always #5 clk = ~clk;

  matrix3x3_arithmetic_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  matrix_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_tdata          (in_tdata),
    .in_tuser          (in_tuser),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata),
    .out_tlast         (out_tlast),
    .mismatch_count    (mismatch_count),
    .elems_outstanding (elems_outstanding)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Holds in_tvalid high between back-to-back words; it is only lowered in a gap.
  task automatic send_word(input logic [OPC_W-1:0] opc, input logic [1:0] row,
                           input logic [1:0] col, input logic [DATA_W-1:0] a_val,
                           input logic [DATA_W-1:0] b_val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= opc;
    in_tdata  <= {4'b0, b_val, a_val, col, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_elem();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = DATA_W'($signed($urandom_range(0, 16)) - 8);
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0000;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic run_random(input int count);
    int                roll;
    logic [OPC_W-1:0]  opc;
    logic [1:0]        row;
    logic [1:0]        col;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        opc = OP_LOAD;
      end else if (roll < 95) begin
        opc = OPC_W'($urandom_range(OP_MUL, OP_TRN));
      end else begin
        opc = OPC_W'($urandom_range(OP_RSVD5, OP_RSVD7));
      end
      // Mostly valid indexes; now and then an out-of-range one.
      row = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      col = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      send_word(opc, row, col, pick_elem(), pick_elem());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Operations on the cleared matrices, then extreme values everywhere.
    send_word(OP_MUL, 2'd0, 2'd0, '0, '0);
    for (int i = 0; i < NELEM; i++) begin
      send_word(OP_LOAD, 2'(i / DIM), 2'(i % DIM),
                (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                (i % 3 == 0) ? 32'hFFFF_FFFF : 32'h8000_0000);
    end
    send_word(OP_MUL, 2'd3, 2'd3, '1, '1);
    send_word(OP_ADD, 2'd0, 2'd0, '0, '0);
    send_word(OP_SUB, 2'd1, 2'd2, '0, '0);
    send_word(OP_TRN, 2'd2, 2'd1, '0, '0);
    // Loads with an index of three must not touch either matrix.
    send_word(OP_LOAD, 2'd3, 2'd0, 32'h1234_5678, 32'h9ABC_DEF0);
    send_word(OP_LOAD, 2'd0, 2'd3, 32'h1234_5678, 32'h9ABC_DEF0);
    send_word(OP_LOAD, 2'd3, 2'd3, 32'h1234_5678, 32'h9ABC_DEF0);
    send_word(OP_RSVD5, 2'd0, 2'd0, '1, '1);
    send_word(OP_RSVD6, 2'd1, 2'd1, '1, '1);
    send_word(OP_RSVD7, 2'd2, 2'd2, '1, '1);
    send_word(OP_SUB, 2'd0, 2'd0, '0, '0);
    send_word(OP_LOAD, 2'd1, 2'd1, 32'd1, 32'hFFFF_FFFF);
    send_word(OP_MUL, 2'd0, 2'd0, '0, '0);

    run_random(RANDOM_WORDS / 4);
    send_idle_pct  = 65;
    run_random(RANDOM_WORDS / 4);
    send_idle_pct  = 0;
    recv_stall_pct = 65;
    run_random(RANDOM_WORDS / 4);
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    run_random(RANDOM_WORDS / 4);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (elems_outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** matrix3x3_arithmetic_unit: PASSED **");
    end else begin
      $display("** matrix3x3_arithmetic_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d result words still expected", elems_outstanding);
    $display("** matrix3x3_arithmetic_unit: FAILED **");
    $finish;
  end

endmodule

@@ matrix3x3_arithmetic_unit.f @@
hdl/m3au_pkg.sv
hdl/m3au_store.sv
hdl/matrix3x3_arithmetic_unit.sv
hdl/m3au_checker.sv
bench/matrix_checker.sv
bench/testbench.sv
